@@ src/booth_radix2_multiplier_macros.svh @@
// Assertion macros for the multiplier source.
`ifndef BOOTH_RADIX2_MULTIPLIER_MACROS_SVH
`define BOOTH_RADIX2_MULTIPLIER_MACROS_SVH

`ifndef SYNTHESIS

// Checked on every clock edge while out of reset.
`define BM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define BM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`else

`define BM_ASSERT(lbl, prop, msg)
`define BM_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

@@ src/bm_pkg.sv @@
// Shared widths, Booth recoding codes and the recoding function.
package bm_pkg;

  // Fixed widths of the item fields.
  localparam int unsigned InWidth   = 16;
  localparam int unsigned ProdWidth = 32;

  // Pair of (multiplier low bit, extra bit) that selects an add or a subtract.
  localparam logic [1:0] PairAdd = 2'b01;
  localparam logic [1:0] PairSub = 2'b10;

  typedef enum logic [1:0] {
    BOOTH_HOLD,
    BOOTH_ADD,
    BOOTH_SUB
  } booth_op_e;

  // Radix-2 Booth recoding of one bit pair.
  function automatic booth_op_e booth_decode(input logic [1:0] pair);
    booth_op_e op;
    unique case (pair)
      PairAdd: op = BOOTH_ADD;
      PairSub: op = BOOTH_SUB;
      default: op = BOOTH_HOLD;
    endcase
    return op;
  endfunction

endpackage

@@ src/bm_if.sv @@
// Valid/ready channel interfaces for operand and product items.
interface bm_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [bm_pkg::InWidth-1:0]    multiplicand;
  logic signed [bm_pkg::InWidth-1:0]    multiplier;

  modport source (output valid, output multiplicand, output multiplier, input ready);
  modport sink   (input valid, input multiplicand, input multiplier, output ready);
endinterface

interface bm_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [bm_pkg::ProdWidth-1:0]  product;

  modport source (output valid, output product, input ready);
  modport sink   (input valid, input product, output ready);
endinterface

@@ src/booth_radix2_multiplier.sv @@
// Pipelined radix-2 Booth multiplier, one recoding step per register stage.
//
//   Channel  Dir  Fields                     Handshake
//   in_i     in   multiplicand, multiplier   valid/ready
//   out_o    out  product                    valid/ready
//
// Each stage does one Booth add/subtract and shift.
// A new item can enter in every cycle while out_o.ready is high, so the sustained rate is one item per cycle.
// Reset clears the stage valid bits only; the data registers are not reset.
// Each stage loads when it is empty or when the stage after it moves on, so a
// stalled output stops only the occupied stages behind it and bubbles close up.
`include "booth_radix2_multiplier_macros.svh"

module booth_radix2_multiplier #(
  parameter int unsigned OPERAND_WIDTH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bm_in_if.sink     in_i,
  bm_out_if.source  out_o
);

  localparam int unsigned W      = OPERAND_WIDTH;
  localparam int unsigned FullW  = 2 * OPERAND_WIDTH;
  localparam int unsigned ProdW  = bm_pkg::ProdWidth;

  // Per-stage state after the step of that stage.
  logic [W-1:0] ac_q  [W];
  logic [W-1:0] mq_q  [W];
  logic [W-1:0] md_q  [W];
  logic         qm1_q [W];
  logic [W-1:0] v_q;

  // Stage k may load when it is empty or its content moves on.
  logic [W:0]   rdy;

  logic [W-1:0] in_md;
  logic [W-1:0] in_mq;
  logic         in_acc;
  logic         out_acc;

  // Inputs are sign-extended or truncated to the operand width.
  assign in_md   = W'(in_i.multiplicand);
  assign in_mq   = W'(in_i.multiplier);
  assign rdy[W]  = out_o.ready;
  assign in_i.ready = rdy[0];
  assign in_acc  = in_i.valid & rdy[0];
  assign out_acc = v_q[W-1] & out_o.ready;

  for (genvar k = 0; k < W; k++) begin : g_step
    logic [W-1:0]      src_ac;
    logic [W-1:0]      src_mq;
    logic [W-1:0]      src_md;
    logic              src_qm1;
    logic              src_v;
    logic [W-1:0]      sum;
    bm_pkg::booth_op_e op;

    // Stage source: the input port for the first step, else the previous stage.
    if (k == 0) begin : g_first
      assign src_ac  = '0;
      assign src_mq  = in_mq;
      assign src_md  = in_md;
      assign src_qm1 = 1'b0;
      assign src_v   = in_i.valid;
    end else begin : g_next
      assign src_ac  = ac_q[k-1];
      assign src_mq  = mq_q[k-1];
      assign src_md  = md_q[k-1];
      assign src_qm1 = qm1_q[k-1];
      assign src_v   = v_q[k-1];
    end

    // Booth add, subtract or hold, wrapping at the operand width.
    always_comb begin
      op = bm_pkg::booth_decode({src_mq[0], src_qm1});
      case (op)
        bm_pkg::BOOTH_ADD: sum = src_ac + src_md;
        bm_pkg::BOOTH_SUB: sum = src_ac - src_md;
        default:           sum = src_ac;
      endcase
    end

    assign rdy[k] = !v_q[k] || rdy[k+1];

    // Stage valid bit.
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        v_q[k] <= src_v;
      end
    end

    // Arithmetic shift of accumulator, multiplier register and extra bit.
    always_ff @(posedge clk_i) begin
      if (rdy[k] && src_v) begin
        ac_q[k]  <= {sum[W-1], sum[W-1:1]};
        mq_q[k]  <= {sum[0], src_mq[W-1:1]};
        qm1_q[k] <= src_mq[0];
        md_q[k]  <= src_md;
      end
    end
  end

  // The product is the low bits of accumulator and multiplier register.
  logic [FullW-1:0] full;
  assign full          = {ac_q[W-1], mq_q[W-1]};
  assign out_o.valid   = v_q[W-1];
  assign out_o.product = ProdW'(full);

  // An accepted item always lands in the first stage.
  `BM_ASSERT(a_enter, in_acc |=> v_q[0], "Accepted item did not enter the first stage.")
  // The first stage carries the multiplicand that was accepted.
  `BM_ASSERT(a_md_capture, in_acc |=> (md_q[0] == $past(in_md)),
             "First stage lost the multiplicand.")
  // Items in flight change only by what enters and what leaves.
  `BM_ASSERT(a_conserve, $past(rst_ni) |->
             (($countones(v_q) + ($past(out_acc) ? 1 : 0)) ==
              ($past($countones(v_q)) + ($past(in_acc) ? 1 : 0))),
             "Pipeline lost or duplicated an item.")
  // A clock edge inside reset leaves no stage occupied.
  `BM_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> (v_q == '0), "Stage valid set during reset.")

endmodule

@@ tb/tb.sv @@
// Testbench for booth_radix2_multiplier: random and corner operands against a Booth predictor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned OPERAND_WIDTH = 16;
  localparam int unsigned RandomItems   = 1850;
  localparam int unsigned InWidth       = bm_pkg::InWidth;
  localparam int unsigned ProdWidth     = bm_pkg::ProdWidth;

  typedef struct packed {
    logic signed [InWidth-1:0] multiplicand;
    logic signed [InWidth-1:0] multiplier;
  } operands_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  bm_in_if  in_if ();
  bm_out_if out_if ();

  booth_radix2_multiplier #(
    .OPERAND_WIDTH(OPERAND_WIDTH)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  operands_t             operand_queue[$];
  logic [ProdWidth-1:0]  product_queue[$];

  int   tx_gap, tx_burst, rx_gap, rx_burst;
  int   products_seen = 0;
  int   mismatches = 0;
  logic long_hold = 1'b0;

  // Free-running clock, 20 ns period.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Radix-2 Booth product: OPERAND_WIDTH add/subtract-and-shift steps on AC:MQ:Q-1.
  function automatic logic [ProdWidth-1:0] booth_product(
    input logic signed [InWidth-1:0] mcand_in,
    input logic signed [InWidth-1:0] mplier_in
  );
    logic [OPERAND_WIDTH-1:0]   acc;
    logic [OPERAND_WIDTH-1:0]   mcand;
    logic [OPERAND_WIDTH-1:0]   mq;
    logic                       q_extra;
    logic [2*OPERAND_WIDTH-1:0] full;
    mcand   = OPERAND_WIDTH'(mcand_in);
    mq      = OPERAND_WIDTH'(mplier_in);
    acc     = '0;
    q_extra = 1'b0;
    for (int unsigned step = 0; step < OPERAND_WIDTH; step++) begin
      case ({mq[0], q_extra})
        bm_pkg::PairAdd: acc = acc + mcand;
        bm_pkg::PairSub: acc = acc - mcand;
        default: ;
      endcase
      q_extra = mq[0];
      mq      = {acc[0], mq[OPERAND_WIDTH-1:1]};
      acc     = {acc[OPERAND_WIDTH-1], acc[OPERAND_WIDTH-1:1]};
    end
    full = {acc, mq};
    return ProdWidth'(full);
  endfunction

  // Idle length: mostly none or short, now and then long, with bursts of no idling.
  function automatic int pick_gap(inout int burst);
    int roll;
    if (burst > 0) begin
      burst--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 5) begin
      burst = $urandom_range(20, 80);
      return 0;
    end
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // One of the boundary operand values.
  function automatic logic signed [InWidth-1:0] edge_operand();
    case ($urandom_range(0, 4))
      0: return 16'sh8000;
      1: return -16'sd1;
      2: return 16'sd0;
      3: return 16'sd1;
      default: return 16'sh7fff;
    endcase
  endfunction

  task automatic add_operands(input logic signed [InWidth-1:0] mcand,
                              input logic signed [InWidth-1:0] mplier);
    operand_queue.push_back('{multiplicand: mcand, multiplier: mplier});
  endtask

  // Operand driver: offers queued items with random gaps between them.
  always @(posedge clk_i or negedge rst_ni) begin : drive_operands
    operands_t next_ops;
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      tx_gap   = 0;
      tx_burst = 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        product_queue.push_back(booth_product(in_if.multiplicand, in_if.multiplier));
        tx_gap = pick_gap(tx_burst);
      end
      if (!in_if.valid || in_if.ready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_if.valid <= 1'b0;
        end else if (operand_queue.size() > 0) begin
          next_ops = operand_queue.pop_front();
          in_if.valid        <= 1'b1;
          in_if.multiplicand <= next_ops.multiplicand;
          in_if.multiplier   <= next_ops.multiplier;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Product monitor: checks each accepted item and stalls ready at random.
  always @(posedge clk_i or negedge rst_ni) begin : check_products
    logic [ProdWidth-1:0] want;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      rx_gap   = 0;
      rx_burst = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        products_seen++;
        if (product_queue.size() == 0) begin
          $error("product %h arrived with no item outstanding", out_if.product);
          mismatches++;
        end else begin
          want = product_queue.pop_front();
          if (out_if.product !== want) begin
            $error("product mismatch: expected %h, actual %h", want, out_if.product);
            mismatches++;
          end
        end
        rx_gap = pick_gap(rx_burst);
      end else if (!out_if.valid && $urandom_range(0, 19) == 0) begin
        rx_gap = pick_gap(rx_burst);
      end
      if (rx_gap > 0) begin
        rx_gap--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= !long_hold;
      end
    end
  end

  // Long receiver hold-offs so the pipeline fills and back-pressures its input.
  initial begin : hold_receiver
    for (int h = 0; h < 2; h++) begin
      while (products_seen < 400 + h * 800) @(posedge clk_i);
      long_hold <= 1'b1;
      repeat (120) @(posedge clk_i);
      long_hold <= 1'b0;
    end
  end

  // Stimulus, reset and end of run.
  initial begin : stimulus
    int roll;
    logic signed [InWidth-1:0] mcand;
    logic signed [InWidth-1:0] mplier;

    // Directed corners: zero, unit, sign limits, alternating bit patterns.
    add_operands(16'sd0, 16'sd0);
    add_operands(16'sd1, 16'sd1);
    add_operands(-16'sd1, -16'sd1);
    add_operands(16'sh7fff, 16'sh7fff);
    add_operands(16'sh8000, 16'sh8000);
    add_operands(16'sh7fff, 16'sh8000);
    add_operands(16'sh8000, 16'sh7fff);
    // Most negative multiplicand wraps the accumulator.
    add_operands(16'sh8000, 16'sd1);
    add_operands(16'sh8000, -16'sd1);
    add_operands(16'sh8000, 16'sd0);
    add_operands(16'sh8000, 16'sh5555);
    add_operands(16'sd0, 16'sh8000);
    add_operands(16'sd1, -16'sd1);
    add_operands(-16'sd1, 16'sh7fff);
    add_operands(16'sh5555, 16'shaaaa);
    add_operands(16'shaaaa, 16'sh5555);
    add_operands(16'sd12345, -16'sd6789);
    add_operands(-16'sd2, 16'sh8000);
    add_operands(16'sh00ff, 16'shff00);
    add_operands(16'shff00, 16'sh00ff);

    // Random operands, weighted toward boundaries and small values.
    for (int n = 0; n < RandomItems; n++) begin
      roll = $urandom_range(0, 9);
      if (roll < 6) begin
        mcand  = InWidth'($urandom);
        mplier = InWidth'($urandom);
      end else if (roll == 6) begin
        mcand  = edge_operand();
        mplier = InWidth'($urandom);
        if ($urandom_range(0, 1)) {mcand, mplier} = {mplier, mcand};
      end else if (roll == 7) begin
        mcand  = InWidth'($urandom_range(0, 16) - 8);
        mplier = InWidth'($urandom_range(0, 16) - 8);
      end else if (roll == 8) begin
        mcand  = edge_operand();
        mplier = edge_operand();
      end else begin
        mcand  = 16'sh8000;
        mplier = InWidth'($urandom);
      end
      add_operands(mcand, mplier);
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (operand_queue.size() != 0 || in_if.valid || product_queue.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (3 * OPERAND_WIDTH) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("booth_radix2_multiplier test passed");
    end else begin
      $display("booth_radix2_multiplier test failed");
    end
    $finish;
  end

  // Watchdog for a hung run.
  initial begin : watchdog
    #20ms;
    $display("booth_radix2_multiplier test failed");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+src
src/bm_pkg.sv
src/bm_if.sv
src/booth_radix2_multiplier.sv
tb/tb.sv
